### hdl/sme_pkg.sv
// Shared types and constants of the small matrix engine.
package sme_pkg;

    // Width of the exact sum of up to eight 64-bit products.
    localparam int unsigned ACC_W = 67;

    typedef enum logic [2:0] {
        OP_LOAD_A = 3'd0,
        OP_LOAD_B = 3'd1,
        OP_ADD    = 3'd2,
        OP_MUL    = 3'd3,
        OP_TRANS  = 3'd4,
        OP_SCALE  = 3'd5,
        OP_DOT    = 3'd6
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHAPE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Control that travels alongside each operand pair into the MAC unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

### hdl/sme_if.sv
// Valid/ready channel interfaces for commands and results.
interface sme_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [2:0]  row_index;
    logic [2:0]  column_index;
    logic signed [31:0] operand_value;

    modport source (output valid, operation, row_index, column_index, operand_value,
                     input ready);
    modport sink (input valid, operation, row_index, column_index, operand_value,
                   output ready);
endinterface

interface sme_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  out_row;
    logic [2:0]  out_column;
    logic signed [31:0] out_value;
    logic        last_item;

    modport source (output valid, status, out_row, out_column, out_value, last_item,
                     input ready);
    modport sink (input valid, status, out_row, out_column, out_value, last_item,
                   output ready);
endinterface

### hdl/sme_mac.sv
// Pipelined multiply-accumulate unit with fixed-point truncation and saturation.
module sme_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sme_pkg::t_mac_ctl   i_ctl,
    input  logic signed [31:0]  i_x,
    input  logic signed [31:0]  i_y,
    output logic                o_valid,
    output logic signed [31:0]  o_value
);

    localparam logic signed [sme_pkg::ACC_W-1:0] MAX_V =
        sme_pkg::ACC_W'(64'sd2147483647);
    localparam logic signed [sme_pkg::ACC_W-1:0] MIN_V = -MAX_V - 1;

    logic signed [63:0]               r_prod;
    sme_pkg::t_mac_ctl                r_ctl;
    logic signed [sme_pkg::ACC_W-1:0] r_acc;
    logic                             r_done;
    logic signed [sme_pkg::ACC_W-1:0] w_prod_ext;
    logic signed [sme_pkg::ACC_W-1:0] w_shift;

    assign w_prod_ext = sme_pkg::ACC_W'(r_prod);
    assign w_shift    = r_acc >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * i_y;
        if (r_ctl.valid) begin
            r_acc <= r_ctl.first ? w_prod_ext : r_acc + w_prod_ext;
        end
        if (w_shift > MAX_V) begin
            o_value <= 32'sh7FFFFFFF;
        end else if (w_shift < MIN_V) begin
            o_value <= 32'sh80000000;
        end else begin
            o_value <= w_shift[31:0];
        end
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_done  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_ctl   <= i_ctl;
            r_done  <= r_ctl.valid && r_ctl.last;
            o_valid <= r_done;
        end
    end

endmodule

### hdl/small_matrix_engine.sv
// Top level of the small matrix engine: sequencer, element memories and result register.
//
// The engine holds matrix A and operand matrix B (each up to MAX_DIM x MAX_DIM signed
// fixed-point words with FRAC_BITS fraction bits) in two on-chip memories; the upper half
// of A's memory serves as scratch space for multiply and transpose. A load transaction
// gives no result. Add, multiply, transpose and scale rewrite A and then stream the new
// A out row-major, one result transaction per element, with last_item on the final one.
// Dot gives a single result and leaves A untouched. The work per command is set by the
// single read port of each memory and the MAC pipeline: add reads, sums and writes back
// each element of B's shape; multiply accumulates B's rows of products for each element
// of the product into scratch, then copies the product back; transpose writes each
// element to scratch, then copies it back; scale passes each element through the MAC;
// dot accumulates B's rows of products. Multiply and scale wait for each MAC result
// before the next element. Errors (A empty, shapes that do not fit) give one result
// transaction with a status code. Commands are taken only when the sequencer is idle,
// but a pending result in the output register does not hold back a new command.
module small_matrix_engine #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sme_cmd_if.sink     i_cmd,
    sme_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int A_DEPTH = 2 * (2 ** AW);
    localparam logic [31:0] DOT_FAIL = ~(32'd1 << FRAC_BITS) + 32'd1;

    localparam logic [1:0] CFG_A_ROWS = 2'd0;
    localparam logic [1:0] CFG_A_COLS = 2'd1;
    localparam logic [1:0] CFG_B_ROWS = 2'd2;
    localparam logic [1:0] CFG_B_COLS = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_RD, S_ADD_WR, S_MUL_RD, S_MUL_WAIT, S_TRN_RD, S_TRN_WR,
        S_CPY_RD, S_CPY_WR, S_SCL_RD, S_SCL_WAIT, S_DOT_RD, S_DOT_WAIT,
        S_ST_RD, S_ST_OUT, S_ONE
    } t_state;

    function automatic logic [AW-1:0] f_addr(input logic [2:0] r, input logic [2:0] c);
        f_addr = AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // A register value of zero counts as one; anything above the maximum is clamped.
    function automatic logic [3:0] f_dim(input logic [3:0] d);
        if (d == 4'd0) begin
            f_dim = 4'd1;
        end else if (d > 4'(MAX_DIM)) begin
            f_dim = 4'(MAX_DIM);
        end else begin
            f_dim = d;
        end
    endfunction

    // Configuration registers.
    logic [3:0] r_cfg_ar, r_cfg_ac, r_cfg_br, r_cfg_bc;

    // Sequencer state.
    t_state         r_state;
    sme_pkg::t_op   r_op;
    logic [3:0]     r_ar, r_ac;
    logic [2:0]     r_r, r_c, r_t;
    logic           r_dot_tr;
    logic signed [31:0] r_val;
    logic [1:0]     r_one_st;
    logic [31:0]    r_one_v;
    sme_pkg::t_mac_ctl r_iss;

    // Output register.
    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic [2:0]  r_o_row, r_o_col;
    logic [31:0] r_o_value;
    logic        r_o_last;

    // Memories and their read data registers. The upper half of A's memory is scratch.
    logic [31:0] a_mem [A_DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] r_a_q, r_b_q;

    logic          a_re, b_re, a_we, b_we;
    logic [AW:0]   a_raddr, a_waddr;
    logic [AW-1:0] b_raddr, b_waddr;
    logic [31:0]   a_wdata;
    sme_pkg::t_mac_ctl iss;

    logic [3:0]  br, bc, lim_r, lim_c, lim_r_m1, lim_c_m1, br_m1;
    logic        r_last, c_last, at_end, t_last, out_free, out_take, accept, in_range;
    logic [2:0]  nxt_r, nxt_c;
    logic signed [32:0] add_sum;
    logic [31:0] add_sat;
    logic        mac_valid;
    logic signed [31:0] mac_value;

    assign br = f_dim(r_cfg_br);
    assign bc = f_dim(r_cfg_bc);

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_o_valid || o_res.ready;
    assign out_take = out_free && (r_state == S_ST_OUT || r_state == S_ONE);
    assign in_range = ({1'b0, i_cmd.row_index} < 4'(MAX_DIM)) &&
                      ({1'b0, i_cmd.column_index} < 4'(MAX_DIM));

    // Loop limits of the element walk in each phase.
    always_comb begin
        case (r_state)
            S_ADD_RD, S_ADD_WR: begin
                lim_r = br;
                lim_c = bc;
            end
            S_MUL_RD, S_MUL_WAIT: begin
                lim_r = r_ar;
                lim_c = bc;
            end
            default: begin
                lim_r = r_ar;
                lim_c = r_ac;
            end
        endcase
    end

    assign lim_r_m1 = lim_r - 4'd1;
    assign lim_c_m1 = lim_c - 4'd1;
    assign br_m1    = br - 4'd1;
    assign r_last   = (r_r == lim_r_m1[2:0]);
    assign c_last   = (r_c == lim_c_m1[2:0]);
    assign at_end   = r_last && c_last;
    assign t_last   = (r_t == br_m1[2:0]);
    assign nxt_c    = c_last ? 3'd0 : r_c + 3'd1;
    assign nxt_r    = c_last ? r_r + 3'd1 : r_r;

    // Add saturates the exact 33-bit sum to 32 bits.
    assign add_sum = {r_a_q[31], r_a_q} + {r_b_q[31], r_b_q};
    assign add_sat = (add_sum[32] != add_sum[31]) ?
                     (add_sum[32] ? 32'h80000000 : 32'h7FFFFFFF) : add_sum[31:0];

    // Memory port control, decoded from the sequencer state.
    always_comb begin
        a_re = 1'b0; b_re = 1'b0;
        a_we = 1'b0; b_we = 1'b0;
        a_raddr = {1'b0, f_addr(r_r, r_c)};
        b_raddr = f_addr(r_r, r_c);
        a_waddr = {1'b0, f_addr(r_r, r_c)};
        b_waddr = f_addr(i_cmd.row_index, i_cmd.column_index);
        a_wdata = add_sat;
        iss     = '0;
        case (r_state)
            S_IDLE: begin
                a_waddr = {1'b0, f_addr(i_cmd.row_index, i_cmd.column_index)};
                a_wdata = i_cmd.operand_value;
                if (accept && in_range) begin
                    a_we = (sme_pkg::t_op'(i_cmd.operation) == sme_pkg::OP_LOAD_A);
                    b_we = (sme_pkg::t_op'(i_cmd.operation) == sme_pkg::OP_LOAD_B);
                end
            end
            S_ADD_RD: begin
                a_re = 1'b1;
                b_re = 1'b1;
            end
            S_ADD_WR: a_we = 1'b1;
            S_MUL_RD: begin
                a_re    = 1'b1;
                b_re    = 1'b1;
                a_raddr = {1'b0, f_addr(r_r, r_t)};
                b_raddr = f_addr(r_t, r_c);
                iss     = '{valid: 1'b1, first: (r_t == 3'd0), last: t_last};
            end
            S_MUL_WAIT: begin
                a_we    = mac_valid;
                a_waddr = {1'b1, f_addr(r_r, r_c)};
                a_wdata = mac_value;
            end
            S_TRN_RD: a_re = 1'b1;
            S_TRN_WR: begin
                a_we    = 1'b1;
                a_waddr = {1'b1, f_addr(r_c, r_r)};
                a_wdata = r_a_q;
            end
            S_CPY_RD: begin
                a_re    = 1'b1;
                a_raddr = {1'b1, f_addr(r_r, r_c)};
            end
            S_CPY_WR: begin
                a_we    = 1'b1;
                a_wdata = r_a_q;
            end
            S_SCL_RD: begin
                a_re = 1'b1;
                iss  = '{valid: 1'b1, first: 1'b1, last: 1'b1};
            end
            S_SCL_WAIT: begin
                a_we    = mac_valid;
                a_wdata = mac_value;
            end
            S_DOT_RD: begin
                a_re    = 1'b1;
                b_re    = 1'b1;
                a_raddr = r_dot_tr ? {1'b0, f_addr(r_t, 3'd0)} : {1'b0, f_addr(3'd0, r_t)};
                b_raddr = f_addr(r_t, 3'd0);
                iss     = '{valid: 1'b1, first: (r_t == 3'd0), last: t_last};
            end
            S_ST_RD: a_re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (a_we) a_mem[a_waddr] <= a_wdata;
        if (a_re) r_a_q <= a_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) b_mem[b_waddr] <= i_cmd.operand_value;
        if (b_re) r_b_q <= b_mem[b_raddr];
    end

    // The read issued in one cycle reaches the MAC in the next, with its control.
    sme_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_iss),
        .i_x     (r_a_q),
        .i_y     ((r_op == sme_pkg::OP_SCALE) ? r_val : r_b_q),
        .o_valid (mac_valid),
        .o_value (mac_value)
    );

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_o_valid;
    assign o_res.status     = r_o_status;
    assign o_res.out_row    = r_o_row;
    assign o_res.out_column = r_o_col;
    assign o_res.out_value  = r_o_value;
    assign o_res.last_item  = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ar      <= 4'd0;
            r_ac      <= 4'd0;
            r_cfg_ar  <= 4'd1;
            r_cfg_ac  <= 4'd1;
            r_cfg_br  <= 4'd1;
            r_cfg_bc  <= 4'd1;
            r_o_valid <= 1'b0;
            r_iss     <= '0;
        end else begin
            r_iss <= iss;
            // A transaction taken by the receiver frees the output register, unless
            // the sequencer refills it in the same cycle.
            if (o_res.ready && !out_take) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_A_ROWS: r_cfg_ar <= i_cfg_data;
                    CFG_A_COLS: r_cfg_ac <= i_cfg_data;
                    CFG_B_ROWS: r_cfg_br <= i_cfg_data;
                    CFG_B_COLS: r_cfg_bc <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_r <= 3'd0;
                    r_c <= 3'd0;
                    r_t <= 3'd0;
                    if (accept) begin
                        r_op  <= sme_pkg::t_op'(i_cmd.operation);
                        r_val <= i_cmd.operand_value;
                        case (sme_pkg::t_op'(i_cmd.operation))
                            sme_pkg::OP_LOAD_A: begin
                                r_ar <= f_dim(r_cfg_ar);
                                r_ac <= f_dim(r_cfg_ac);
                            end
                            sme_pkg::OP_LOAD_B: ;
                            sme_pkg::OP_ADD, sme_pkg::OP_MUL, sme_pkg::OP_TRANS,
                            sme_pkg::OP_SCALE, sme_pkg::OP_DOT: begin
                                if (r_ar == 4'd0) begin
                                    // A has never been loaded.
                                    r_one_v  <= 32'd0;
                                    r_one_st <= sme_pkg::ST_EMPTY;
                                    r_state  <= S_ONE;
                                end else begin
                                    // A failed dot reports minus one, other failures zero.
                                    r_one_st <= sme_pkg::ST_SHAPE;
                                    r_one_v  <= (sme_pkg::t_op'(i_cmd.operation) ==
                                                 sme_pkg::OP_DOT) ? DOT_FAIL : 32'd0;
                                    case (sme_pkg::t_op'(i_cmd.operation))
                                        sme_pkg::OP_ADD:
                                            r_state <= (r_ar < br || r_ac < bc) ?
                                                       S_ONE : S_ADD_RD;
                                        sme_pkg::OP_MUL:
                                            r_state <= (r_ac != br) ? S_ONE : S_MUL_RD;
                                        sme_pkg::OP_TRANS: r_state <= S_TRN_RD;
                                        sme_pkg::OP_SCALE: r_state <= S_SCL_RD;
                                        default: begin
                                            // Dot tries A first, then A transposed.
                                            r_dot_tr <= (r_ac != br);
                                            if (r_ac == br || r_ar == br) begin
                                                r_state <= S_DOT_RD;
                                            end else begin
                                                r_state <= S_ONE;
                                            end
                                        end
                                    endcase
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ADD_RD: r_state <= S_ADD_WR;
                S_ADD_WR: begin
                    r_r     <= at_end ? 3'd0 : nxt_r;
                    r_c     <= at_end ? 3'd0 : nxt_c;
                    r_state <= at_end ? S_ST_RD : S_ADD_RD;
                end
                S_MUL_RD: begin
                    r_t <= t_last ? 3'd0 : r_t + 3'd1;
                    if (t_last) begin
                        r_state <= S_MUL_WAIT;
                    end
                end
                S_MUL_WAIT: begin
                    if (mac_valid) begin
                        r_r <= at_end ? 3'd0 : nxt_r;
                        r_c <= at_end ? 3'd0 : nxt_c;
                        if (at_end) begin
                            // The product takes B's column count.
                            r_ac    <= bc;
                            r_state <= S_CPY_RD;
                        end else begin
                            r_state <= S_MUL_RD;
                        end
                    end
                end
                S_TRN_RD: r_state <= S_TRN_WR;
                S_TRN_WR: begin
                    r_r <= at_end ? 3'd0 : nxt_r;
                    r_c <= at_end ? 3'd0 : nxt_c;
                    if (at_end) begin
                        r_ar    <= r_ac;
                        r_ac    <= r_ar;
                        r_state <= S_CPY_RD;
                    end else begin
                        r_state <= S_TRN_RD;
                    end
                end
                S_CPY_RD: r_state <= S_CPY_WR;
                S_CPY_WR: begin
                    r_r     <= at_end ? 3'd0 : nxt_r;
                    r_c     <= at_end ? 3'd0 : nxt_c;
                    r_state <= at_end ? S_ST_RD : S_CPY_RD;
                end
                S_SCL_RD: r_state <= S_SCL_WAIT;
                S_SCL_WAIT: begin
                    if (mac_valid) begin
                        r_r     <= at_end ? 3'd0 : nxt_r;
                        r_c     <= at_end ? 3'd0 : nxt_c;
                        r_state <= at_end ? S_ST_RD : S_SCL_RD;
                    end
                end
                S_DOT_RD: begin
                    r_t <= r_t + 3'd1;
                    if (t_last) begin
                        r_state <= S_DOT_WAIT;
                    end
                end
                S_DOT_WAIT: begin
                    if (mac_valid) begin
                        r_one_st <= sme_pkg::ST_OK;
                        r_one_v  <= mac_value;
                        r_state  <= S_ONE;
                    end
                end
                S_ST_RD: r_state <= S_ST_OUT;
                S_ST_OUT: begin
                    // The read data register holds until the output register frees up.
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= sme_pkg::ST_OK;
                        r_o_row    <= r_r;
                        r_o_col    <= r_c;
                        r_o_value  <= r_a_q;
                        r_o_last   <= at_end;
                        r_r        <= nxt_r;
                        r_c        <= nxt_c;
                        r_state    <= at_end ? S_IDLE : S_ST_RD;
                    end
                end
                S_ONE: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_one_st;
                        r_o_row    <= 3'd0;
                        r_o_col    <= 3'd0;
                        r_o_value  <= r_one_v;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
